[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define RBF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rbf_pkg.sv]
// Types and constants of the row box filter.
package rbf_pkg;

   localparam int R_MAX_DEF        = 31;
   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int WINDOW_DEPTH_DEF = 64;

   localparam int FIELD_W    = 16;
   localparam int RADIUS_W   = 5;
   localparam int RECIP_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int SEEN_W     = 7;

   localparam logic [SEEN_W-1:0]   SEEN_MAX     = 7'd127;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;
   localparam logic [RECIP_W-1:0]  RECIP_RESET  = 16'd21845;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 1'b0,
      CSR_RECIP  = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [FIELD_W-1:0] pixel_ch0;
      logic [FIELD_W-1:0] pixel_ch1;
      logic [FIELD_W-1:0] pixel_ch2;
      logic               row_end;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_W-1:0] avg_ch0;
      logic [FIELD_W-1:0] avg_ch1;
      logic [FIELD_W-1:0] avg_ch2;
      logic               final_of_run;
      logic               final_of_row;
   } rsp_payload_type;

   typedef struct packed {
      logic accept;
      logic issue;
      logic scale;
      logic next_d;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_emit;
      logic j_last;
      logic run_done;
   } dp_status_type;

endpackage

[rtl/rbf_ram.sv]
// Generic single-port-write, registered-read RAM.
module rbf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rbf_ctrl.sv]
// Sequencer of the row box filter: accept, window read, scale, result beat.
module rbf_ctrl import rbf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.accept = req_valid && !stall_ff;
      cmd.issue  = (state_ff == ST_ISSUE);
      cmd.scale  = (state_ff == ST_SCALE);
      cmd.next_d = (state_ff == ST_OUTPUT) && !rsp_stall && !status.run_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stall_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && status.start_emit) begin
                  state_ff <= ST_ISSUE;
                  stall_ff <= 1'b1;
               end
            end
            ST_ISSUE: begin
               if (status.j_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               state_ff     <= ST_OUTPUT;
               rsp_valid_ff <= 1'b1;
            end
            ST_OUTPUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  if (status.run_done) begin
                     state_ff <= ST_IDLE;
                     stall_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_ISSUE;
                  end
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               stall_ff     <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/rbf_datapath.sv]
// Datapath: window store, clamp addressing, window sums and scaling.
module rbf_datapath import rbf_pkg::*; #(
   parameter int R_MAX        = R_MAX_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output rsp_payload_type       rsp_payload
);

   localparam int RLIM  = (R_MAX < (WINDOW_DEPTH - 1) / 2) ? R_MAX : (WINDOW_DEPTH - 1) / 2;
   localparam int RW    = $clog2(RLIM + 1);
   localparam int JW    = $clog2(2 * RLIM + 1);
   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int SW    = SAMPLE_BITS;
   localparam int SUM_W = SAMPLE_BITS + JW;
   localparam int PW    = SUM_W + RECIP_W;
   localparam int PIX_W = 3 * SAMPLE_BITS;
   localparam int EXT_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;

   logic [RADIUS_W-1:0] radius_ff;
   logic [RECIP_W-1:0]  recip_ff;
   logic [SEEN_W-1:0]   seen_ff;
   logic [AW-1:0]       slot_ff;
   logic [PIX_W-1:0]    first_ff;
   logic [AW-1:0]       cur_ff;
   logic [SEEN_W-1:0]   n_ff;
   logic [RW-1:0]       r_ff;
   logic [RW-1:0]       d_ff;
   logic [JW-1:0]       j_ff;
   logic                last_ff;
   logic                rd_valid_ff;
   logic                sel_first_ff;
   logic [SUM_W-1:0]    acc0_ff, acc1_ff, acc2_ff;
   logic [PW-1:0]       prod0_ff, prod1_ff, prod2_ff;

   logic [RW-1:0]       r_eff;
   logic [RW-1:0]       d_init;
   logic [PIX_W-1:0]    pix_in;
   logic [JW:0]         back;
   logic                back_neg;
   logic [JW-1:0]       back_mag;
   logic [AW:0]         diff;
   logic [AW-1:0]       rd_addr;
   logic                use_first;
   logic [PIX_W-1:0]    ram_rd_data;
   logic [PIX_W-1:0]    src;

   function automatic logic [FIELD_W-1:0] round_sat(input logic [PW-1:0] p);
      logic [PW:0]    rnd;
      logic [SUM_W:0] v;
      logic [SW-1:0]  sat;
      rnd = {1'b0, p} + (PW + 1)'(1 << (RECIP_W - 1));
      v   = rnd[PW:RECIP_W];
      sat = (|v[SUM_W:SW]) ? {SW{1'b1}} : v[SW-1:0];
      return FIELD_W'(sat);
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         recip_ff  <= RECIP_RESET;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_RADIUS: radius_ff <= csr_data[RADIUS_W-1:0];
            CSR_RECIP:  recip_ff  <= csr_data[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   assign r_eff  = (radius_ff > RADIUS_W'(RLIM)) ? RW'(RLIM) : RW'(radius_ff);
   assign d_init = (req_payload.row_end && (seen_ff < SEEN_W'(r_eff))) ? RW'(seen_ff) : r_eff;
   assign pix_in = {SW'(EXT_W'(req_payload.pixel_ch2)),
                    SW'(EXT_W'(req_payload.pixel_ch1)),
                    SW'(EXT_W'(req_payload.pixel_ch0))};

   // window position of tap j, counted back from the current pixel
   assign back      = (JW + 1)'(d_ff) + (JW + 1)'(r_ff) - (JW + 1)'(j_ff);
   assign back_neg  = back[JW];
   assign back_mag  = back[JW-1:0];
   assign diff      = (AW + 1)'(cur_ff) - (AW + 1)'(back_mag);
   assign use_first = !back_neg && (n_ff < SEEN_MAX) && (SEEN_W'(back_mag) > n_ff);

   always_comb begin
      if (back_neg) begin
         rd_addr = cur_ff;
      end else if (diff[AW]) begin
         rd_addr = AW'(diff + (AW + 1)'(WINDOW_DEPTH));
      end else begin
         rd_addr = diff[AW-1:0];
      end
   end

   rbf_ram #(
      .WIDTH (PIX_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (slot_ff),
      .wr_data (pix_in),
      .rd_en   (cmd.issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         slot_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue;
         if (cmd.accept) begin
            if (req_payload.row_end) begin
               seen_ff <= '0;
               slot_ff <= '0;
            end else begin
               seen_ff <= (seen_ff < SEEN_MAX) ? seen_ff + 1'b1 : SEEN_MAX;
               slot_ff <= (slot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sel_first_ff <= use_first;
      if (cmd.accept) begin
         cur_ff  <= slot_ff;
         n_ff    <= seen_ff;
         r_ff    <= r_eff;
         d_ff    <= d_init;
         j_ff    <= '0;
         last_ff <= req_payload.row_end;
         if (seen_ff == '0) begin
            first_ff <= pix_in;
         end
      end else if (cmd.next_d) begin
         d_ff <= d_ff - 1'b1;
         j_ff <= '0;
      end else if (cmd.issue) begin
         j_ff <= j_ff + 1'b1;
      end
   end

   assign src = sel_first_ff ? first_ff : ram_rd_data;

   always_ff @(posedge clock) begin
      priority if (cmd.accept || cmd.next_d) begin
         acc0_ff <= '0;
         acc1_ff <= '0;
         acc2_ff <= '0;
      end else if (rd_valid_ff) begin
         acc0_ff <= acc0_ff + SUM_W'(src[SW-1:0]);
         acc1_ff <= acc1_ff + SUM_W'(src[2*SW-1:SW]);
         acc2_ff <= acc2_ff + SUM_W'(src[3*SW-1:2*SW]);
      end
      if (cmd.scale) begin
         prod0_ff <= acc0_ff * recip_ff;
         prod1_ff <= acc1_ff * recip_ff;
         prod2_ff <= acc2_ff * recip_ff;
      end
   end

   assign status.start_emit = req_payload.row_end || (seen_ff >= SEEN_W'(r_eff));
   assign status.j_last     = (j_ff == JW'({r_ff, 1'b0}));
   assign status.run_done   = !last_ff || (d_ff == '0);

   assign rsp_payload.avg_ch0      = round_sat(prod0_ff);
   assign rsp_payload.avg_ch1      = round_sat(prod1_ff);
   assign rsp_payload.avg_ch2      = round_sat(prod2_ff);
   assign rsp_payload.final_of_run = status.run_done;
   assign rsp_payload.final_of_row = last_ff && (d_ff == '0);

endmodule

[rtl/row_box_filter_clamped.sv]
// Top level of the horizontal box filter with edge clamp.
// Pixels enter on the req_ channel (three 16-bit channels and a row_end flag);
// window means leave on the rsp_ channel. A beat moves when valid is high and
// stall is low. radius and window_reciprocal are written through the csr_
// channel (index 0 and 1); the user must write them only while the block is
// idle, which the block itself does not enforce. csr_ready is always high.
// The first r pixels of a row give no result; each later pixel gives one
// result, and the pixel with row_end flushes up to r+1 results in order.
// Each result reads its 2r+1 window taps, one tap per cycle, from the window
// RAM or the held first pixel of the row, then scales the three sums for the
// result beat. A pixel that gives no result leaves req_stall low. req_stall
// stays high from an accept that gives results until its last result beat is
// taken. While rsp_stall is high the result beat holds. Reset clears the
// sequencer, row position and registers (radius 1, reciprocal 21845); the
// window RAM is not cleared; only entries written in the current row are used.
module row_box_filter_clamped import rbf_pkg::*; #(
   parameter int R_MAX        = R_MAX_DEF,
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   rbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   rbf_datapath #(
      .R_MAX        (R_MAX),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/rbf_checker.sv]
// Port-level checker of the row box filter, bound to the top level.
`include "assert_macros.svh"

module rbf_checker import rbf_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_payload
);

   `RBF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped while stalled")
   `RBF_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_payload), "stalled result changed")
   `RBF_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "result beat right after reset")
   `RBF_ASSERT(a_busy_stall, clock, reset, rsp_valid |-> req_stall, "input taken while a result is pending")
   `RBF_ASSERT(a_row_run, clock, reset, rsp_valid && rsp_payload.final_of_row |-> rsp_payload.final_of_run, "row end not closing the run")

endmodule

bind row_box_filter_clamped rbf_checker u_rbf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
